>>> src/kv_command_frame_parser_macros.svh
// Assertion macros shared by the command frame parser RTL.
`ifndef KV_COMMAND_FRAME_PARSER_MACROS_SVH
`define KV_COMMAND_FRAME_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
`define KVCFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("kvcfp assertion failed");
`define KVCFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("kvcfp assertion failed");
`else
`define KVCFP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KVCFP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/kvcfp_pkg.sv
// Types and constants of the command frame parser.
package kvcfp_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int LEN_BYTES       = 4;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] TAG_PUT    = 8'h01;
  localparam logic [7:0] TAG_DELETE = 8'h02;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_KLEN,
    PH_KEY,
    PH_VLEN,
    PH_VAL,
    PH_DONE,
    PH_OVER
  } phase_e;

  typedef enum logic [1:0] {
    KIND_KEY,
    KIND_VALUE,
    KIND_STATUS
  } kind_e;

  typedef enum logic [1:0] {
    ST_PUT,
    ST_DELETE,
    ST_TRUNC,
    ST_UNKNOWN
  } status_e;

  // One parsed input byte: an optional payload byte and an optional status.
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data;
    logic        is_value;
    logic        has_status;
    status_e     status;
    logic [31:0] klen;
    logic [31:0] vlen;
  } ev_t;

endpackage

>>> src/kvcfp_front.sv
// Front end: frame header state machine, classifies each byte into an event.
module kvcfp_front import kvcfp_pkg::*; #(
  parameter int LengthBits = LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_data_i,
  input  logic       in_end_i,
  input  logic       q_ready_i,
  output logic       ev_push_o,
  output ev_t        ev_o
);

  phase_e                phase_q, phase_d;
  logic [7:0]            tag_q, tag_d;
  logic [1:0]            hcnt_q, hcnt_d;
  logic [31:0]           shift_q, shift_d;
  logic [LengthBits-1:0] rem_q, rem_d;
  logic [31:0]           klen_q, klen_d;
  logic [31:0]           vlen_q, vlen_d;
  logic                  fire;
  logic [31:0]           shift_new;
  logic                  len_over;
  logic                  hdr_last;
  ev_t                   ev;

  assign in_ready_o = q_ready_i;
  assign fire       = in_valid_i & q_ready_i;
  assign shift_new  = {shift_q[23:0], in_data_i};
  assign len_over   = (shift_new >> LengthBits) != 32'd0;
  assign hdr_last   = hcnt_q == 2'(LEN_BYTES - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      tag_q   <= '0;
      hcnt_q  <= '0;
      shift_q <= '0;
      rem_q   <= '0;
      klen_q  <= '0;
      vlen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      hcnt_q  <= hcnt_d;
      shift_q <= shift_d;
      rem_q   <= rem_d;
      klen_q  <= klen_d;
      vlen_q  <= vlen_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    tag_d   = tag_q;
    hcnt_d  = hcnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    klen_d  = klen_q;
    vlen_d  = vlen_q;
    ev      = '0;
    if (fire) begin
      case (phase_q)
        PH_TAG: begin
          tag_d   = in_data_i;
          klen_d  = '0;
          vlen_d  = '0;
          hcnt_d  = '0;
          shift_d = '0;
          rem_d   = '0;
          phase_d = PH_KLEN;
        end
        PH_KLEN: begin
          shift_d = shift_new;
          if (hdr_last) begin
            hcnt_d = '0;
            klen_d = shift_new;
            if (len_over) begin
              phase_d = PH_OVER;
            end else if (shift_new == 32'd0) begin
              shift_d = '0;
              phase_d = (tag_q == TAG_PUT) ? PH_VLEN : PH_DONE;
            end else begin
              rem_d   = shift_new[LengthBits-1:0];
              phase_d = PH_KEY;
            end
          end else begin
            hcnt_d = hcnt_q + 2'd1;
          end
        end
        PH_KEY: begin
          ev.has_data = 1'b1;
          ev.data     = in_data_i;
          ev.is_value = 1'b0;
          rem_d       = rem_q - LengthBits'(1);
          if (rem_q == LengthBits'(1)) begin
            hcnt_d  = '0;
            shift_d = '0;
            phase_d = (tag_q == TAG_PUT) ? PH_VLEN : PH_DONE;
          end
        end
        PH_VLEN: begin
          shift_d = shift_new;
          if (hdr_last) begin
            hcnt_d = '0;
            vlen_d = shift_new;
            if (len_over) begin
              phase_d = PH_OVER;
            end else if (shift_new == 32'd0) begin
              phase_d = PH_DONE;
            end else begin
              rem_d   = shift_new[LengthBits-1:0];
              phase_d = PH_VAL;
            end
          end else begin
            hcnt_d = hcnt_q + 2'd1;
          end
        end
        PH_VAL: begin
          ev.has_data = 1'b1;
          ev.data     = in_data_i;
          ev.is_value = 1'b1;
          rem_d       = rem_q - LengthBits'(1);
          if (rem_q == LengthBits'(1)) begin
            phase_d = PH_DONE;
          end
        end
        default: begin
        end
      endcase

      if (in_end_i) begin
        ev.has_status = 1'b1;
        if (phase_d != PH_DONE) begin
          ev.status = ST_TRUNC;
        end else if (tag_d == TAG_PUT) begin
          ev.status = ST_PUT;
        end else if (tag_d == TAG_DELETE) begin
          ev.status = ST_DELETE;
        end else begin
          ev.status = ST_UNKNOWN;
        end
        ev.klen = klen_d;
        ev.vlen = (tag_d == TAG_PUT) ? vlen_d : 32'd0;
        phase_d = PH_TAG;
        hcnt_d  = '0;
        shift_d = '0;
        rem_d   = '0;
      end
    end
  end

  assign ev_push_o = fire & (ev.has_data | ev.has_status);
  assign ev_o      = ev;

endmodule

>>> src/kvcfp_queue.sv
// Small event queue between the parser front end and the result back end.
module kvcfp_queue import kvcfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ev_t  push_ev_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output ev_t  head_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  ev_t           ent_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign ready_o = count_q != CW'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = ent_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

>>> src/kvcfp_back.sv
// Back end: expands queued events into result requests in an output register.
module kvcfp_back import kvcfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  ev_t         q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output kind_e       out_kind_o,
  output status_e     out_status_o,
  output logic [31:0] out_klen_o,
  output logic [31:0] out_vlen_o,
  output logic        out_last_o
);

  logic        valid_q, valid_d;
  logic        sub_q, sub_d;
  logic [7:0]  byte_q, byte_d;
  kind_e       kind_q, kind_d;
  status_e     status_q, status_d;
  logic [31:0] klen_q, klen_d;
  logic [31:0] vlen_q, vlen_d;
  logic        last_q, last_d;
  logic        load;

  assign load = q_valid_i & (~valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sub_q   <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    kind_q   <= kind_d;
    status_q <= status_d;
    klen_q   <= klen_d;
    vlen_q   <= vlen_d;
    last_q   <= last_d;
  end

  always_comb begin
    valid_d  = valid_q & ~out_ready_i;
    sub_d    = sub_q;
    byte_d   = byte_q;
    kind_d   = kind_q;
    status_d = status_q;
    klen_d   = klen_q;
    vlen_d   = vlen_q;
    last_d   = last_q;
    q_pop_o  = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      if (q_head_i.has_data && !sub_q) begin
        byte_d   = q_head_i.data;
        kind_d   = q_head_i.is_value ? KIND_VALUE : KIND_KEY;
        status_d = ST_PUT;
        klen_d   = '0;
        vlen_d   = '0;
        last_d   = ~q_head_i.has_status;
        sub_d    = q_head_i.has_status;
        q_pop_o  = ~q_head_i.has_status;
      end else begin
        byte_d   = '0;
        kind_d   = KIND_STATUS;
        status_d = q_head_i.status;
        klen_d   = q_head_i.klen;
        vlen_d   = q_head_i.vlen;
        last_d   = 1'b1;
        sub_d    = 1'b0;
        q_pop_o  = 1'b1;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign out_kind_o   = kind_q;
  assign out_status_o = status_q;
  assign out_klen_o   = klen_q;
  assign out_vlen_o   = vlen_q;
  assign out_last_o   = last_q;

endmodule

>>> src/kv_command_frame_parser.sv
// Top level of the command frame parser: front end, event queue and back end.
// Takes one frame byte per cycle while the event queue has room, tlast on the
// frame's final byte. Key and value bytes come out as they arrive (tuser says key or
// value); after the final byte a status request follows with both decoded lengths
// and tlast set. The output register moves one request per cycle while the sink is
// ready, so a final byte that is also a payload byte makes two requests, absorbed by
// the four-entry event queue.
`include "kv_command_frame_parser_macros.svh"

module kv_command_frame_parser import kvcfp_pkg::*; #(
  parameter int LengthBits = LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [9:8] frame_status, [41:10] key_length, [73:42] value_length
  output logic [79:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // [1:0] out_kind
  output logic        m_axis_tlast
);

  logic        ev_push;
  ev_t         ev;
  logic        q_ready;
  logic        q_valid;
  logic        q_pop;
  ev_t         q_head;
  logic [7:0]  out_byte;
  kind_e       out_kind;
  status_e     out_status;
  logic [31:0] out_klen;
  logic [31:0] out_vlen;

  kvcfp_front #(
    .LengthBits(LengthBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_data_i (s_axis_tdata),
    .in_end_i  (s_axis_tlast),
    .q_ready_i (q_ready),
    .ev_push_o (ev_push),
    .ev_o      (ev)
  );

  kvcfp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (ev_push),
    .push_ev_i(ev),
    .ready_o  (q_ready),
    .pop_i    (q_pop),
    .valid_o  (q_valid),
    .head_o   (q_head)
  );

  kvcfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_kind_o  (out_kind),
    .out_status_o(out_status),
    .out_klen_o  (out_klen),
    .out_vlen_o  (out_vlen),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_vlen, out_klen, out_status, out_byte};
  assign m_axis_tuser = out_kind;

  `KVCFP_ASSERT_IMP(a_status_shape, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser == KIND_STATUS,
    m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
  `KVCFP_ASSERT_IMP(a_byte_fields_zero, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser != KIND_STATUS,
    m_axis_tdata[79:8] == 72'd0)
  `KVCFP_ASSERT_NXT(a_status_follows, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tready && m_axis_tuser != KIND_STATUS && !m_axis_tlast,
    m_axis_tvalid && m_axis_tuser == KIND_STATUS)

endmodule
